// ===== rtl/core/bcd_pkg.sv =====
package bcd_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned THR_W  = 16;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_MIN_CLICK  = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS = 2'd2;

    localparam logic [THR_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [THR_W-1:0] MIN_CLICK_RST  = 16'd20;
    localparam logic [THR_W-1:0] LONG_PRESS_RST = 16'd1000;

    localparam logic [1:0] EVT_NONE  = 2'd0;
    localparam logic [1:0] EVT_CLICK = 2'd1;
    localparam logic [1:0] EVT_LONG  = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              button_level;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       pressed;
    } out_item_t;

    typedef struct packed {
        logic [THR_W-1:0] debounce_ms;
        logic [THR_W-1:0] min_click_ms;
        logic [THR_W-1:0] long_press_ms;
    } cfg_t;

endpackage

// ===== rtl/core/bcd_cfg.sv =====
module bcd_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bcd_pkg::ADDR_W-1:0]   paddr,
    input  logic [bcd_pkg::DATA_W-1:0]   pwdata,
    output logic [bcd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output bcd_pkg::cfg_t                cfg
);

    bcd_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms   <= bcd_pkg::DEBOUNCE_RST;
            cfg_reg.min_click_ms  <= bcd_pkg::MIN_CLICK_RST;
            cfg_reg.long_press_ms <= bcd_pkg::LONG_PRESS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                bcd_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ms   <= pwdata[bcd_pkg::THR_W-1:0];
                bcd_pkg::REG_MIN_CLICK:  cfg_reg.min_click_ms  <= pwdata[bcd_pkg::THR_W-1:0];
                bcd_pkg::REG_LONG_PRESS: cfg_reg.long_press_ms <= pwdata[bcd_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bcd_pkg::REG_DEBOUNCE:
                prdata = {{(bcd_pkg::DATA_W-bcd_pkg::THR_W){1'b0}}, cfg_reg.debounce_ms};
            bcd_pkg::REG_MIN_CLICK:
                prdata = {{(bcd_pkg::DATA_W-bcd_pkg::THR_W){1'b0}}, cfg_reg.min_click_ms};
            bcd_pkg::REG_LONG_PRESS:
                prdata = {{(bcd_pkg::DATA_W-bcd_pkg::THR_W){1'b0}}, cfg_reg.long_press_ms};
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/bcd_fsm.sv =====
module bcd_fsm (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  bcd_pkg::in_item_t  item,
    input  bcd_pkg::cfg_t      cfg,
    output bcd_pkg::out_item_t result
);

    typedef enum logic [1:0] {
        PH_UP       = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_DOWN     = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [bcd_pkg::TIME_W-1:0] change_time_reg, change_time_next;
    logic [bcd_pkg::TIME_W-1:0] press_start_reg, press_start_next;
    logic [bcd_pkg::TIME_W-1:0] since_change, since_press;
    logic                      down;
    logic [1:0]                evt;

    assign down = !item.button_level;

    // modulo 2^32 elapsed time, so a timestamp wrap still gives the true interval
    assign since_change = item.now_ms - change_time_reg;
    assign since_press  = item.now_ms - press_start_reg;

    always_comb begin
        phase_next       = phase_reg;
        change_time_next = change_time_reg;
        press_start_next = press_start_reg;
        evt              = bcd_pkg::EVT_NONE;
        case (phase_reg)
            PH_UP: begin
                if (down) begin
                    phase_next       = PH_DEBOUNCE;
                    change_time_next = item.now_ms;
                end
            end
            PH_DEBOUNCE: begin
                if (!down) begin
                    phase_next = PH_UP;
                end else if (since_change >= {16'd0, cfg.debounce_ms}) begin
                    phase_next       = PH_DOWN;
                    press_start_next = item.now_ms;
                end
            end
            PH_DOWN: begin
                if (!down) begin
                    if (since_press >= {16'd0, cfg.min_click_ms}) begin
                        evt = bcd_pkg::EVT_CLICK;
                    end
                    phase_next = PH_UP;
                end else if (since_press >= {16'd0, cfg.long_press_ms}) begin
                    evt        = bcd_pkg::EVT_LONG;
                    phase_next = PH_LONG;
                end
            end
            default: begin
                if (!down) begin
                    phase_next = PH_UP;
                end
            end
        endcase
    end

    assign result.event_res = evt;
    assign result.pressed   = down;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_UP;
            change_time_reg <= '0;
            press_start_reg <= '0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            change_time_reg <= change_time_next;
            press_start_reg <= press_start_next;
        end
    end

endmodule

// ===== rtl/core/bcd_skid.sv =====
module bcd_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  bcd_pkg::out_item_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bcd_pkg::out_item_t out_data
);

    bcd_pkg::out_item_t out_reg, skid_reg;
    logic               out_valid_reg, skid_valid_reg;
    logic               take, out_free;

    assign in_ready  = !skid_valid_reg;
    assign take      = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (take) begin
                out_reg <= in_data;
            end
        end else if (take) begin
            skid_reg <= in_data;
        end
    end

endmodule

// ===== rtl/core/button_click_long_press_detector_top.sv =====
// Debounced button click and long-press detector. Each input transaction is one
// poll sample (millisecond timestamp, raw active-low level) and yields exactly
// one result transaction with the event (none, click, long press) and the
// pressed level for an LED. A sample is taken every cycle: the phase machine
// and its two timestamps update in the accept cycle and the result lands in a
// two-entry output stage, so s_ready drops only when that stage is full.
// Thresholds sit at byte addresses 0, 4 and 8 of the
// APB port and should be written while no transaction is in flight.
module button_click_long_press_detector_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bcd_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bcd_pkg::out_item_t         m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bcd_pkg::ADDR_W-1:0] paddr,
    input  logic [bcd_pkg::DATA_W-1:0] pwdata,
    output logic [bcd_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    bcd_pkg::cfg_t      cfg;
    bcd_pkg::out_item_t result;
    logic               accept;

    assign accept = s_valid && s_ready;

    bcd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcd_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .cfg     (cfg),
        .result  (result)
    );

    bcd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ===== rtl/core/bcd_chk.sv =====
module bcd_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input bcd_pkg::out_item_t  m_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_evt_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.event_res == bcd_pkg::EVT_NONE ||
                     m_data.event_res == bcd_pkg::EVT_CLICK ||
                     m_data.event_res == bcd_pkg::EVT_LONG))
        else $error("bad event code");

    // input only backs up when an output is pending
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // after an accepted sample the output is always valid next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted sample produced no result");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output not empty after reset");

endmodule

bind button_click_long_press_detector_top bcd_chk u_bcd_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
